// File: sv/erg_pkg.sv
// Shared types and constants for the Euclidean rhythm generator.
package erg_pkg;

  // Largest step count that is expanded; longer requests give an all-rest pattern.
  localparam int unsigned MAX_STEPS = 32;

  // Width of the beat, step, quotient and remainder values.
  localparam int unsigned VAL_W     = 6;
  // Depth of the Euclid table. Values below 64 need at most about ten levels.
  localparam int unsigned LVL_N     = 16;
  localparam int unsigned LVL_W     = $clog2(LVL_N);
  // Output pattern width.
  localparam int unsigned PAT_W     = 32;
  // One quotient bit per divider cycle.
  localparam int unsigned DIV_STEPS = VAL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Step codes shifted into the pattern.
  localparam logic BIT_REST = 1'b0;
  localparam logic BIT_BEAT = 1'b1;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [LVL_W-1:0] lvl_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_TOP    = 4'b0100,
    ST_EXPAND = 4'b1000
  } state_t;

endpackage

// File: sv/euclidean_rhythm_generator.sv
// Euclidean rhythm generator: Euclid table by a shared divider, then stack-free expansion.
//
//  channel | signals                      | transfer
//  --------+------------------------------+------------------------------------------
//  request | start, busy, beats, steps    | taken at an edge with start high, busy low
//  result  | done, pattern, too_many_beats| done high one cycle, taken at its end edge
//
// Sequence: beats above steps, zero beats or steps, or steps above MAX_STEPS answer in the
// next cycle. Otherwise the shared divider builds the Euclid table level by level, the
// top level is loaded, and the walker then emits steps, entering and leaving levels;
// done follows once the top level is finished. Reset: rst (synchronous) idles, drops done.
// Stalls: busy holds from acceptance to the result cycle; the receiver cannot stall.
module euclidean_rhythm_generator
  import erg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [VAL_W-1:0] beats,
  input  logic [VAL_W-1:0] steps,
  output logic             done,
  output logic [PAT_W-1:0] pattern,
  output logic             too_many_beats
);

  state_t state;

  // Euclid table: per level the repeat count of the level below and the remainder.
  val_t lvl_cnt [LVL_N];
  val_t lvl_rem [LVL_N];
  // Walker bookkeeping: children expanded, remainder child taken, calling level.
  val_t lvl_done  [LVL_N];
  logic lvl_rdone [LVL_N];
  lvl_t lvl_par   [LVL_N];

  // Table build registers.
  lvl_t lv;         // level being divided
  val_t dvsr;       // running dividend
  val_t cur_rem;    // remainder at level lv, the divisor of this division

  // Shared restoring divider.
  val_t                 dv_r;
  val_t                 dv_q;
  val_t                 dv_d;
  logic [DIV_CNT_W-1:0] dv_k;

  // Walker registers.
  lvl_t             cur;
  lvl_t             top;
  logic [PAT_W-1:0] acc;

  // Divider datapath: one trial subtract per cycle.
  logic [VAL_W:0] dv_trial;
  logic           dv_ge;
  val_t           dv_r_next;
  val_t           dv_q_next;
  logic           dv_last;

  // Walker decisions at the current level.
  logic has_child;
  logic take_rem;
  logic emit;
  logic emit_bit;
  logic descend;
  lvl_t child;

  // Request classification.
  logic req_over;
  logic req_empty;

  assign busy = (state != ST_IDLE);

  assign req_over  = (beats > steps);
  assign req_empty = (beats == '0) || (steps == '0) ||
                     ({1'b0, steps} > (VAL_W + 1)'(MAX_STEPS));

  always_comb begin
    dv_trial  = {dv_r, dv_q[VAL_W-1]};
    dv_ge     = (dv_trial >= {1'b0, dv_d});
    dv_r_next = dv_ge ? VAL_W'(dv_trial - {1'b0, dv_d}) : dv_trial[VAL_W-1:0];
    dv_q_next = {dv_q[VAL_W-2:0], dv_ge};
    dv_last   = (dv_k == DIV_CNT_W'(DIV_STEPS - 1));
  end

  // A level first repeats the level below lvl_cnt times, then, with a nonzero
  // remainder, appends the level two below. Levels below zero are single steps:
  // one below level zero is a rest, two below is a beat.
  always_comb begin
    has_child = (lvl_done[cur] != lvl_cnt[cur]);
    take_rem  = !has_child && (lvl_rem[cur] != '0) && !lvl_rdone[cur];
    emit      = (has_child && (cur == '0)) || (take_rem && (cur < LVL_W'(2)));
    emit_bit  = (take_rem && (cur == '0)) ? BIT_BEAT : BIT_REST;
    descend   = (has_child || take_rem) && !emit;
    child     = has_child ? LVL_W'(cur - LVL_W'(1)) : LVL_W'(cur - LVL_W'(2));
  end

  // Sequencer and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (req_over || req_empty) begin
              // Answer at once; the pattern is all rests either way.
              done <= 1'b1;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // Stop once the new remainder drops to one or zero.
          if (dv_last && (dv_r_next <= VAL_W'(1))) begin
            state <= ST_TOP;
          end
        end
        ST_TOP: begin
          state <= ST_EXPAND;
        end
        ST_EXPAND: begin
          if (!has_child && !take_rem && (cur == top)) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: table build, divider and walker.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          pattern        <= '0;
          too_many_beats <= req_over;
          acc            <= '0;
          lv             <= '0;
          dvsr           <= VAL_W'(steps - beats);
          cur_rem        <= beats;
          lvl_rem[0]     <= beats;
          dv_r           <= '0;
          dv_q           <= VAL_W'(steps - beats);
          dv_d           <= beats;
          dv_k           <= '0;
        end
      end
      ST_DIV: begin
        if (dv_last) begin
          // Store quotient and remainder, advance a level, reload the divider.
          lvl_cnt[lv]            <= dv_q_next;
          lvl_rem[lv + LVL_W'(1)] <= dv_r_next;
          lv                     <= lv + LVL_W'(1);
          dvsr                   <= cur_rem;
          cur_rem                <= dv_r_next;
          dv_r                   <= '0;
          dv_q                   <= cur_rem;
          dv_d                   <= dv_r_next;
          dv_k                   <= '0;
        end else begin
          dv_r <= dv_r_next;
          dv_q <= dv_q_next;
          dv_k <= dv_k + DIV_CNT_W'(1);
        end
      end
      ST_TOP: begin
        // The top level repeats the divisor of the last division.
        lvl_cnt[lv]   <= dvsr;
        lvl_done[lv]  <= '0;
        lvl_rdone[lv] <= 1'b0;
        cur           <= lv;
        top           <= lv;
      end
      ST_EXPAND: begin
        if (has_child) begin
          lvl_done[cur] <= lvl_done[cur] + VAL_W'(1);
        end
        if (take_rem) begin
          lvl_rdone[cur] <= 1'b1;
        end
        if (emit) begin
          acc <= {acc[PAT_W-2:0], emit_bit};
        end
        if (descend) begin
          lvl_done[child]  <= '0;
          lvl_rdone[child] <= 1'b0;
          lvl_par[child]   <= cur;
          cur              <= child;
        end else if (!has_child && !take_rem) begin
          if (cur == top) begin
            pattern <= acc;
          end else begin
            // Return to the calling level.
            cur <= lvl_par[cur];
          end
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // The result strobe only comes with the sequencer back at idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // A request with more beats than steps answers next cycle with the flag and no beats.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (beats > steps)) |=> (done && too_many_beats && (pattern == '0)))
    else $error("too many beats not reported");

  // The divider never runs with a zero divisor.
  assert property (@(posedge clk) disable iff (rst) (state == ST_DIV) |-> (dv_d != '0))
    else $error("division by zero");

  // The walker never climbs above the top level.
  assert property (@(posedge clk) disable iff (rst) (state == ST_EXPAND) |-> (cur <= top))
    else $error("walker above top level");

  // A flagged result never carries beats.
  assert property (@(posedge clk) disable iff (rst)
    (done && too_many_beats) |-> (pattern == '0))
    else $error("flagged result with beats");

endmodule
